// ----- hw/rtl/ddsp_pkg.sv -----
// Package for the dense shortest-path block: sizes, modes and edge-store helpers.
// Used by ddsp_edge_mem and dense_dijkstra_shortest_paths.
`timescale 1ns / 1ps

package ddsp_pkg;

    localparam int MaxVertices = 64;
    localparam int VertBits    = $clog2(MaxVertices);
    localparam int CountBits   = VertBits + 1;
    localparam int WeightBits  = 16;
    localparam int DistBits    = 32;
    localparam int EdgeDepth   = MaxVertices * MaxVertices;
    localparam int EdgeBits    = 2 * VertBits;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_RUN   = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_COUNT = 1'b0;
    localparam logic CFG_INF   = 1'b1;

    localparam logic signed [DistBits-1:0] DistMax = {1'b0, {(DistBits-1){1'b1}}};
    localparam logic signed [DistBits-1:0] DistMin = {1'b1, {(DistBits-1){1'b0}}};

    // One read request to the edge store.
    typedef struct packed {
        logic                rd_en;
        logic [EdgeBits-1:0] rd_addr;
    } t_edge_rd;

    // Saturating distance plus weight.
    function automatic logic signed [DistBits-1:0] sat_add(
        input logic signed [DistBits-1:0]   d,
        input logic signed [WeightBits-1:0] w
    );
        logic signed [DistBits:0] s;
        s = $signed({d[DistBits-1], d}) + $signed((DistBits+1)'(w));
        if (s > $signed({DistMax[DistBits-1], DistMax})) return DistMax;
        if (s < $signed({DistMin[DistBits-1], DistMin})) return DistMin;
        return s[DistBits-1:0];
    endfunction

endpackage

// ----- hw/rtl/ddsp_edge_mem.sv -----
// Edge store: cost memory plus a presence memory, with registered reads.
// Depends on ddsp_pkg.
`timescale 1ns / 1ps

module ddsp_edge_mem (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [ddsp_pkg::EdgeBits-1:0]   i_wr_addr,
    input  logic [ddsp_pkg::WeightBits-1:0] i_wr_cost,
    input  logic                            i_clear,
    input  ddsp_pkg::t_edge_rd              i_rd,
    output logic                            o_busy,
    output logic                            o_present,
    output logic [ddsp_pkg::WeightBits-1:0] o_cost
);
    import ddsp_pkg::*;

    // A clear, and reset, start a sweep that zeroes one presence entry per cycle.
    logic [WeightBits-1:0] mem_cost [EdgeDepth];
    logic                  mem_on   [EdgeDepth];
    logic                  r_sweep;
    logic [EdgeBits-1:0]   r_sweep_addr;
    logic                  on_we;
    logic [EdgeBits-1:0]   on_addr;
    logic                  on_data;

    // Sweep control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep      <= 1'b1;
            r_sweep_addr <= '0;
        end else if (r_sweep) begin
            r_sweep_addr <= r_sweep_addr + EdgeBits'(1);
            if (r_sweep_addr == EdgeBits'(EdgeDepth - 1)) r_sweep <= 1'b0;
        end else if (i_clear) begin
            r_sweep      <= 1'b1;
            r_sweep_addr <= '0;
        end
    end

    // The presence write port is shared by the sweep and edge loads.
    always_comb begin
        on_we   = r_sweep || i_wr_en;
        on_addr = r_sweep ? r_sweep_addr : i_wr_addr;
        on_data = !r_sweep;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && !r_sweep) mem_cost[i_wr_addr] <= i_wr_cost;
        if (on_we) mem_on[on_addr] <= on_data;
        if (i_rd.rd_en) begin
            o_cost    <= mem_cost[i_rd.rd_addr];
            o_present <= mem_on[i_rd.rd_addr];
        end
    end

    assign o_busy = r_sweep;

endmodule

// ----- hw/rtl/dense_dijkstra_shortest_paths.sv -----
// Top level of the dense-array shortest-path engine.
// Depends on ddsp_pkg and ddsp_edge_mem.
`timescale 1ns / 1ps

// A clear item starts a sweep that clears the edge-present memory one entry a cycle;
// the same sweep runs after reset, and input is held off while it runs. A run on n
// vertices in use first writes the vertex records and, if the start is in range,
// relaxes the start's out-edges, then settles each further vertex with a minimum scan,
// a pick step and a relax pass, with one vertex memory read a cycle and, in relax
// passes, one edge memory read a cycle. A run that stops early ends with one last scan
// that finds no vertex. Results then stream out in vertex order, one item at a time:
// the next record is read only after the last is taken at the output handshake. Input
// is held off from the accepted run item until its last result item is taken.
module dense_dijkstra_shortest_paths (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[1:0]
    input  logic [1:0]  s_axis_tuser,
    // edge_from[5:0], edge_to[11:6], edge_weight[27:12], start_vertex[33:28]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // vertex[5:0], distance[37:6], has_predecessor[38], predecessor[44:39],
    // settle_order[51:45]
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import ddsp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_INIT  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_PICK  = 7'b0001000,
        S_RELAX = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;
    logic [CountBits-1:0] r_count;
    logic signed [31:0]   r_inf_cfg;
    logic [CountBits-1:0] r_n;
    logic signed [DistBits-1:0] r_inf;
    logic [VertBits-1:0]  r_start;
    logic [CountBits-1:0] r_k;
    logic [CountBits-1:0] r_idx;
    logic                 r_rvld;
    logic [VertBits-1:0]  r_ridx;
    logic signed [DistBits-1:0] r_best;
    logic [VertBits:0]    r_bpred;
    logic                 r_found;
    logic [VertBits-1:0]  r_pick;
    logic signed [DistBits-1:0] r_udist;

    // Vertex record memory: distance, predecessor (valid bit + index), settle position.
    logic signed [DistBits-1:0] mem_dist [MaxVertices];
    logic [VertBits:0]          mem_pred [MaxVertices];
    logic [CountBits-1:0]       mem_pos  [MaxVertices];
    logic                 v_we;
    logic [VertBits-1:0]  v_waddr;
    logic signed [DistBits-1:0] v_wdist;
    logic [VertBits:0]    v_wpred;
    logic [CountBits-1:0] v_wpos;
    logic                 v_re;
    logic [VertBits-1:0]  v_raddr;
    logic signed [DistBits-1:0] r_vdist;
    logic [VertBits:0]    r_vpred;
    logic [CountBits-1:0] r_vpos;

    logic [1:0]           in_mode;
    logic [VertBits-1:0]  in_from, in_to, in_start;
    logic [WeightBits-1:0] in_weight;
    logic                 in_acc;
    t_edge_rd             e_rd;
    logic                 e_busy;
    logic                 e_present;
    logic [WeightBits-1:0] e_cost;
    logic signed [DistBits-1:0] sum;
    logic [CountBits-1:0] cnt_eff;
    logic                 r_oval;
    logic [55:0]          r_odata;
    logic                 r_olast;

    assign in_mode   = s_axis_tuser;
    assign in_from   = s_axis_tdata[5:0];
    assign in_to     = s_axis_tdata[11:6];
    assign in_weight = s_axis_tdata[27:12];
    assign in_start  = s_axis_tdata[33:28];
    assign s_axis_tready = (r_state == S_IDLE) && !e_busy;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    assign cnt_eff = (r_count == '0) ? CountBits'(1) :
                     (r_count > CountBits'(MaxVertices)) ? CountBits'(MaxVertices) : r_count;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= CountBits'(MaxVertices);
            r_inf_cfg <= 32'sh7fffffff;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_COUNT) r_count <= i_cfg_data[CountBits-1:0];
            else r_inf_cfg <= i_cfg_data;
        end
    end

    ddsp_edge_mem u_edge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (in_acc && in_mode == MODE_LOAD),
        .i_wr_addr ({in_from, in_to}),
        .i_wr_cost (in_weight),
        .i_clear   (in_acc && in_mode == MODE_CLEAR),
        .i_rd      (e_rd),
        .o_busy    (e_busy),
        .o_present (e_present),
        .o_cost    (e_cost)
    );

    // Vertex memory ports.
    always_ff @(posedge i_clk) begin
        if (v_we) begin
            mem_dist[v_waddr] <= v_wdist;
            mem_pred[v_waddr] <= v_wpred;
            mem_pos[v_waddr]  <= v_wpos;
        end
        if (v_re) begin
            r_vdist <= mem_dist[v_raddr];
            r_vpred <= mem_pred[v_raddr];
            r_vpos  <= mem_pos[v_raddr];
        end
    end

    assign sum = sat_add(r_udist, e_cost);

    // Memory request and write-back logic. Reads are issued for index r_idx; the
    // record returns next cycle tagged by r_ridx. Relax writes land before the next read
    // of the same entry because indexes only increase within a pass.
    always_comb begin
        v_we = 1'b0; v_waddr = r_ridx; v_wdist = r_vdist; v_wpred = r_vpred; v_wpos = r_vpos;
        v_re = 1'b0; v_raddr = r_idx[VertBits-1:0];
        e_rd.rd_en = 1'b0; e_rd.rd_addr = {r_pick, r_idx[VertBits-1:0]};
        unique case (r_state)
            S_INIT: begin
                v_we = 1'b1; v_waddr = r_idx[VertBits-1:0];
                v_wdist = (r_idx[VertBits-1:0] == r_start) ? '0 : r_inf;
                v_wpred = '0;
                v_wpos  = (r_idx[VertBits-1:0] == r_start) ? CountBits'(1) : '0;
            end
            S_SCAN: v_re = (r_idx < r_n);
            // One read per result item; the next waits for the output handshake.
            S_EMIT: v_re = !r_rvld;
            S_PICK: begin
                v_we = 1'b1; v_waddr = r_pick; v_wdist = r_best;
                v_wpred = r_bpred; v_wpos = r_k;
            end
            S_RELAX: begin
                v_re = (r_idx < r_n);
                e_rd.rd_en = (r_idx < r_n);
                if (r_rvld && e_present && r_vpos == '0 && r_vdist > sum) begin
                    v_we = 1'b1; v_wdist = sum; v_wpred = {1'b1, r_pick};
                end
            end
            S_IDLE, S_OUT: ;
            default: ;
        endcase
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rvld  <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_rvld <= v_re;
            r_ridx <= v_raddr;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && in_mode == MODE_RUN) begin
                        r_n     <= cnt_eff;
                        r_inf   <= r_inf_cfg;
                        r_start <= in_start;
                        r_idx   <= '0;
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_idx <= r_idx + CountBits'(1);
                    if (r_idx + CountBits'(1) == r_n) begin
                        r_idx <= '0;
                        if (CountBits'(r_start) < r_n) begin
                            r_pick  <= r_start;
                            r_udist <= '0;
                            r_k     <= CountBits'(1);
                            r_state <= S_RELAX;
                        end else r_state <= S_EMIT;
                    end
                end
                S_SCAN: begin
                    if (r_idx < r_n) r_idx <= r_idx + CountBits'(1);
                    if (r_rvld && r_vpos == '0 && r_vdist < r_best) begin
                        r_best  <= r_vdist; r_pick <= r_ridx;
                        r_bpred <= r_vpred; r_found <= 1'b1;
                    end
                    if (r_idx == r_n && !r_rvld) begin
                        if (r_found) r_state <= S_PICK;
                        else begin
                            r_idx <= '0; r_state <= S_EMIT;
                        end
                    end
                end
                S_PICK: begin
                    r_udist <= r_best;
                    r_idx   <= '0;
                    r_state <= S_RELAX;
                end
                S_RELAX: begin
                    if (r_idx < r_n) r_idx <= r_idx + CountBits'(1);
                    else if (!r_rvld) begin
                        r_idx <= '0;
                        if (r_k == r_n) r_state <= S_EMIT;
                        else begin
                            r_k <= r_k + CountBits'(1);
                            r_best <= r_inf; r_found <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_EMIT: begin
                    if (r_rvld) begin
                        r_oval  <= 1'b1;
                        r_odata <= {4'd0, r_vpos,
                                    r_vpred[VertBits] ? r_vpred[VertBits-1:0] : VertBits'(0),
                                    r_vpred[VertBits], r_vdist, r_ridx};
                        r_olast <= (r_idx + CountBits'(1) == r_n);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_oval <= 1'b0;
                        if (r_olast) r_state <= S_IDLE;
                        else begin
                            r_idx   <= r_idx + CountBits'(1);
                            r_state <= S_EMIT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    // The output register only holds an item while the output state is active.
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_state == S_OUT) else $error("output valid outside output state");
    // Input is never taken during a run.
    a_no_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !s_axis_tready) else $error("input ready during run");
    // The settle counter never passes the vertex count.
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_PICK) |-> r_k <= r_n)
        else $error("settle position overrun");

endmodule
